>>> hw/rtl/lpmq_pkg.sv
// shared types and constants for the length-prefixed message queue
package lpmq_pkg;

   // bytes in a stored length header
   localparam int unsigned HEADER_BYTES = 4;

   // request function codes
   typedef enum logic [1:0] {
      FN_START = 2'd0,
      FN_DATA  = 2'd1,
      FN_READ  = 2'd2,
      FN_CLEAR = 2'd3
   } lpmq_func_type;

   // result status codes
   typedef enum logic [3:0] {
      RS_ACCEPTED = 4'd0,
      RS_NO_SPACE = 4'd1,
      RS_IGNORED  = 4'd2,
      RS_STORED   = 4'd3,
      RS_BYTE_OUT = 4'd4,
      RS_EMPTY    = 4'd5,
      RS_DROPPED  = 4'd6,
      RS_CLEARED  = 4'd7,
      RS_ZERO_LEN = 4'd8
   } lpmq_status_type;

   // controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_HDR_WR,
      S_HDR1,
      S_HDR2,
      S_HDR3,
      S_EVAL,
      S_RD_DATA,
      S_WAIT
   } lpmq_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic            load;       // capture request fields
      logic            wr_start;   // write header byte 0, open message
      logic            wr_hdr;     // write next header byte
      logic            wr_data;    // write payload byte
      logic            clear;      // empty the ring
      logic            take;       // read one byte and advance read pointer
      logic            cap_lo;     // capture header low byte
      logic            cap_hi;     // capture header high bits
      logic            drop;       // skip the whole payload
      logic            pop_zero;   // retire a zero-length message
      logic            setup;      // prepare payload delivery
      logic            deliver;    // current take produces a result
      logic            emit;       // issue a single result
      lpmq_status_type emit_status;
   } lpmq_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      lpmq_func_type func;
      logic          open;       // a message is still receiving bytes
      logic          no_space;   // header plus payload does not fit
      logic          empty;      // no complete message header queued
      logic          hdr_last;   // last header byte is being written
      logic          mlen_over;  // message longer than the reader limit
      logic          mlen_zero;  // message has no payload
      logic          cnt_one;    // final payload byte is being read
   } lpmq_stat_type;

endpackage

>>> hw/rtl/length_prefixed_message_queue.sv
// top level of the length-prefixed message queue: controller plus datapath
//
//   channel   ports                                   handshake
//   request   req_func, req_message_length,           start high while busy low
//             req_data_byte, req_read_limit
//   result    rsp_status, rsp_out_byte, rsp_last,     rsp_strobe high for one cycle
//             rsp_popped_length
//
// data byte, clear, ignored or rejected start, empty read: busy only in the execute state
// accepted start: busy while the four header bytes go one by one through the ram write port
// read: EXEC, HDR1 to HDR3 and EVAL read the header and decide (all of a dropped or
// zero-length pop), then RD_DATA delivers one byte per cycle and WAIT ends the read
// status results are on rsp the cycle after they are decided; the receiver cannot stall
// reset is synchronous and leaves the queue empty; ring contents are not cleared
module length_prefixed_message_queue #(
   parameter int RING_BYTES = 1024,
   parameter int MAX_READ   = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_func,
   input  logic [9:0] req_message_length,
   input  logic [7:0] req_data_byte,
   input  logic [6:0] req_read_limit,
   output logic       rsp_strobe,
   output logic [3:0] rsp_status,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   output logic [9:0] rsp_popped_length
);

   lpmq_pkg::lpmq_cmd_type  cmd;
   lpmq_pkg::lpmq_stat_type stat;

   // sequencing
   lpmq_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (busy),
      .stat (stat),
      .cmd  (cmd)
   );

   // storage and arithmetic
   lpmq_datapath #(
      .RING_BYTES(RING_BYTES),
      .MAX_READ  (MAX_READ)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_func          (req_func),
      .req_message_length(req_message_length),
      .req_data_byte     (req_data_byte),
      .req_read_limit    (req_read_limit),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last          (rsp_last),
      .rsp_popped_length (rsp_popped_length)
   );

endmodule

>>> hw/rtl/lpmq_ram.sv
// generic single-port-write, single-port-read ram with registered read
module lpmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/lpmq_datapath.sv
// ring pointers, counters, byte store and result register of the queue
module lpmq_datapath #(
   parameter int RING_BYTES = 1024,
   parameter int MAX_READ   = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             req_func,
   input  logic [9:0]             req_message_length,
   input  logic [7:0]             req_data_byte,
   input  logic [6:0]             req_read_limit,
   input  lpmq_pkg::lpmq_cmd_type cmd,
   output lpmq_pkg::lpmq_stat_type stat,
   output logic                   rsp_strobe,
   output logic [3:0]             rsp_status,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_last,
   output logic [9:0]             rsp_popped_length
);

   localparam int PW = $clog2(RING_BYTES);
   localparam int CW = $clog2(RING_BYTES + 1);
   localparam int SW = ((CW > 11) ? CW : 11) + 1;
   localparam int AW = ((PW > 10) ? PW : 10) + 1;

   // captured request
   lpmq_pkg::lpmq_func_type func_ff;
   logic [9:0]  len_ff;
   logic [7:0]  byte_ff;
   logic [6:0]  lim_ff;

   // queue state
   logic [PW-1:0] rp_ff, rp_in;
   logic [PW-1:0] wp_ff, wp_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] committed_ff, committed_in;
   logic [9:0]    outstanding_ff, outstanding_in;
   logic [9:0]    open_len_ff, open_len_in;

   // sequencing state
   logic [1:0]  hcnt_ff, hcnt_in;
   logic [9:0]  mlen_ff, mlen_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        dly_ff, dly_in;
   logic        dly_last_ff, dly_last_in;

   // result register
   logic                      rsp_strobe_ff, rsp_strobe_in;
   lpmq_pkg::lpmq_status_type rsp_status_ff, rsp_status_in;
   logic [7:0]                rsp_byte_ff, rsp_byte_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic [9:0]                rsp_plen_ff, rsp_plen_in;

   // ram port signals
   logic          ram_we;
   logic [7:0]    ram_wdata;
   logic [7:0]    ram_rdata;

   // arithmetic helpers
   logic [PW-1:0] wp_step, rp_step;
   logic [AW-1:0] rp_sum;
   logic [CW-1:0] free_space;
   logic [SW-1:0] need_space;
   logic [CW-1:0] mlen_c, open_len_c;

   lpmq_ram #(
      .WIDTH(8),
      .DEPTH(RING_BYTES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(wp_ff),
      .wr_data(ram_wdata),
      .rd_addr(rp_ff),
      .rd_data(ram_rdata)
   );

   // pointer steps and space check
   always_comb begin
      wp_step    = (wp_ff == PW'(RING_BYTES - 1)) ? '0 : wp_ff + 1'b1;
      rp_step    = (rp_ff == PW'(RING_BYTES - 1)) ? '0 : rp_ff + 1'b1;
      rp_sum     = AW'(rp_ff) + AW'(mlen_ff);
      free_space = CW'(RING_BYTES) - fill_ff;
      need_space = SW'(len_ff) + SW'(lpmq_pkg::HEADER_BYTES);
      mlen_c     = CW'(mlen_ff);
      open_len_c = CW'(open_len_ff);
   end

   // status to the controller
   always_comb begin
      stat.func      = func_ff;
      stat.open      = (outstanding_ff != '0);
      stat.no_space  = (SW'(free_space) < need_space);
      stat.empty     = (committed_ff < CW'(lpmq_pkg::HEADER_BYTES));
      stat.hdr_last  = (hcnt_ff == 2'd3);
      stat.mlen_over = (mlen_ff > {3'b000, lim_ff});
      stat.mlen_zero = (mlen_ff == '0);
      stat.cnt_one   = (cnt_ff == 7'd1);
   end

   // ram write selection
   always_comb begin
      ram_we    = cmd.wr_start | cmd.wr_hdr | cmd.wr_data;
      ram_wdata = 8'h00;
      if (cmd.wr_start) begin
         ram_wdata = len_ff[7:0];
      end else if (cmd.wr_hdr) begin
         ram_wdata = (hcnt_ff == 2'd1) ? {6'b000000, len_ff[9:8]} : 8'h00;
      end else if (cmd.wr_data) begin
         ram_wdata = byte_ff;
      end
   end

   // next queue state
   always_comb begin
      rp_in          = rp_ff;
      wp_in          = wp_ff;
      fill_in        = fill_ff;
      committed_in   = committed_ff;
      outstanding_in = outstanding_ff;
      open_len_in    = open_len_ff;
      hcnt_in        = hcnt_ff;
      mlen_in        = mlen_ff;
      cnt_in         = cnt_ff;
      dly_in         = 1'b0;
      dly_last_in    = 1'b0;

      if (cmd.clear) begin
         rp_in          = '0;
         wp_in          = '0;
         fill_in        = '0;
         committed_in   = '0;
         outstanding_in = '0;
         open_len_in    = '0;
      end

      // header byte 0 opens the message
      if (cmd.wr_start) begin
         wp_in          = wp_step;
         fill_in        = fill_ff + 1'b1;
         outstanding_in = len_ff;
         open_len_in    = len_ff;
         hcnt_in        = 2'd1;
         if (len_ff == '0) begin
            committed_in = committed_ff + CW'(lpmq_pkg::HEADER_BYTES);
         end
      end

      if (cmd.wr_hdr) begin
         wp_in   = wp_step;
         fill_in = fill_ff + 1'b1;
         hcnt_in = hcnt_ff + 1'b1;
      end

      // payload byte, message completes on the final one
      if (cmd.wr_data) begin
         wp_in          = wp_step;
         fill_in        = fill_ff + 1'b1;
         outstanding_in = outstanding_ff - 1'b1;
         if (outstanding_ff == 10'd1) begin
            committed_in = committed_ff + open_len_c + CW'(lpmq_pkg::HEADER_BYTES);
         end
      end

      if (cmd.take) begin
         rp_in   = rp_step;
         fill_in = fill_ff - 1'b1;
      end

      if (cmd.cap_lo) begin
         mlen_in = {2'b00, ram_rdata};
      end
      if (cmd.cap_hi) begin
         mlen_in = {ram_rdata[1:0], mlen_ff[7:0]};
      end

      // skip payload with one wrapped add
      if (cmd.drop) begin
         rp_in        = (rp_sum >= AW'(RING_BYTES)) ? PW'(rp_sum - AW'(RING_BYTES))
                                                   : PW'(rp_sum);
         fill_in      = fill_ff - mlen_c;
         committed_in = committed_ff - mlen_c - CW'(lpmq_pkg::HEADER_BYTES);
      end

      if (cmd.pop_zero) begin
         committed_in = committed_ff - CW'(lpmq_pkg::HEADER_BYTES);
      end

      if (cmd.setup) begin
         committed_in = committed_ff - mlen_c - CW'(lpmq_pkg::HEADER_BYTES);
         cnt_in       = mlen_ff[6:0];
      end

      // tag the read whose data becomes a result next cycle
      if (cmd.deliver) begin
         cnt_in      = cnt_ff - 1'b1;
         dly_in      = 1'b1;
         dly_last_in = (cnt_ff == 7'd1);
      end
   end

   // next result
   always_comb begin
      rsp_strobe_in = 1'b0;
      rsp_status_in = lpmq_pkg::RS_ACCEPTED;
      rsp_byte_in   = 8'h00;
      rsp_last_in   = 1'b0;
      rsp_plen_in   = '0;
      if (cmd.emit) begin
         rsp_strobe_in = 1'b1;
         rsp_status_in = cmd.emit_status;
         rsp_last_in   = 1'b1;
         if (cmd.emit_status == lpmq_pkg::RS_DROPPED) begin
            rsp_plen_in = mlen_ff;
         end
      end else if (dly_ff) begin
         rsp_strobe_in = 1'b1;
         rsp_status_in = lpmq_pkg::RS_BYTE_OUT;
         rsp_byte_in   = ram_rdata;
         rsp_last_in   = dly_last_ff;
         rsp_plen_in   = mlen_ff;
      end
   end

   // request capture, limit clipped to the reader maximum
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= lpmq_pkg::lpmq_func_type'(req_func);
         len_ff  <= req_message_length;
         byte_ff <= req_data_byte;
         lim_ff  <= (req_read_limit > 7'(MAX_READ)) ? 7'(MAX_READ) : req_read_limit;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff          <= '0;
         wp_ff          <= '0;
         fill_ff        <= '0;
         committed_ff   <= '0;
         outstanding_ff <= '0;
         open_len_ff    <= '0;
         hcnt_ff        <= '0;
         cnt_ff         <= '0;
         dly_ff         <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         rp_ff          <= rp_in;
         wp_ff          <= wp_in;
         fill_ff        <= fill_in;
         committed_ff   <= committed_in;
         outstanding_ff <= outstanding_in;
         open_len_ff    <= open_len_in;
         hcnt_ff        <= hcnt_in;
         cnt_ff         <= cnt_in;
         dly_ff         <= dly_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mlen_ff       <= mlen_in;
      dly_last_ff   <= dly_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_plen_ff   <= rsp_plen_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_popped_length = rsp_plen_ff;

endmodule

>>> hw/rtl/lpmq_ctrl.sv
// controller state machine sequencing each request of the queue
module lpmq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  lpmq_pkg::lpmq_stat_type stat,
   output lpmq_pkg::lpmq_cmd_type  cmd
);

   lpmq_pkg::lpmq_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lpmq_pkg::S_IDLE: begin
            if (start) begin
               state_in = lpmq_pkg::S_EXEC;
            end
         end
         lpmq_pkg::S_EXEC: begin
            state_in = lpmq_pkg::S_IDLE;
            if (stat.func == lpmq_pkg::FN_START && !stat.open && !stat.no_space) begin
               state_in = lpmq_pkg::S_HDR_WR;
            end else if (stat.func == lpmq_pkg::FN_READ && !stat.empty) begin
               state_in = lpmq_pkg::S_HDR1;
            end
         end
         lpmq_pkg::S_HDR_WR: begin
            if (stat.hdr_last) begin
               state_in = lpmq_pkg::S_IDLE;
            end
         end
         lpmq_pkg::S_HDR1: state_in = lpmq_pkg::S_HDR2;
         lpmq_pkg::S_HDR2: state_in = lpmq_pkg::S_HDR3;
         lpmq_pkg::S_HDR3: state_in = lpmq_pkg::S_EVAL;
         lpmq_pkg::S_EVAL: begin
            if (stat.mlen_over || stat.mlen_zero) begin
               state_in = lpmq_pkg::S_IDLE;
            end else begin
               state_in = lpmq_pkg::S_RD_DATA;
            end
         end
         lpmq_pkg::S_RD_DATA: begin
            if (stat.cnt_one) begin
               state_in = lpmq_pkg::S_WAIT;
            end
         end
         lpmq_pkg::S_WAIT: state_in = lpmq_pkg::S_IDLE;
         default: state_in = lpmq_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         lpmq_pkg::S_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         lpmq_pkg::S_EXEC: begin
            cmd.emit = 1'b1;
            unique case (stat.func)
               lpmq_pkg::FN_START: begin
                  if (stat.open) begin
                     cmd.emit_status = lpmq_pkg::RS_IGNORED;
                  end else if (stat.no_space) begin
                     cmd.emit_status = lpmq_pkg::RS_NO_SPACE;
                  end else begin
                     cmd.wr_start    = 1'b1;
                     cmd.emit_status = lpmq_pkg::RS_ACCEPTED;
                  end
               end
               lpmq_pkg::FN_DATA: begin
                  if (stat.open) begin
                     cmd.wr_data     = 1'b1;
                     cmd.emit_status = lpmq_pkg::RS_STORED;
                  end else begin
                     cmd.emit_status = lpmq_pkg::RS_IGNORED;
                  end
               end
               lpmq_pkg::FN_READ: begin
                  if (stat.empty) begin
                     cmd.emit_status = lpmq_pkg::RS_EMPTY;
                  end else begin
                     cmd.emit = 1'b0;
                     cmd.take = 1'b1;
                  end
               end
               lpmq_pkg::FN_CLEAR: begin
                  cmd.clear       = 1'b1;
                  cmd.emit_status = lpmq_pkg::RS_CLEARED;
               end
               default: cmd.emit = 1'b0;
            endcase
         end
         lpmq_pkg::S_HDR_WR: cmd.wr_hdr = 1'b1;
         lpmq_pkg::S_HDR1: begin
            cmd.take   = 1'b1;
            cmd.cap_lo = 1'b1;
         end
         lpmq_pkg::S_HDR2: begin
            cmd.take   = 1'b1;
            cmd.cap_hi = 1'b1;
         end
         lpmq_pkg::S_HDR3: cmd.take = 1'b1;
         lpmq_pkg::S_EVAL: begin
            if (stat.mlen_over) begin
               cmd.drop        = 1'b1;
               cmd.emit        = 1'b1;
               cmd.emit_status = lpmq_pkg::RS_DROPPED;
            end else if (stat.mlen_zero) begin
               cmd.pop_zero    = 1'b1;
               cmd.emit        = 1'b1;
               cmd.emit_status = lpmq_pkg::RS_ZERO_LEN;
            end else begin
               cmd.setup = 1'b1;
            end
         end
         lpmq_pkg::S_RD_DATA: begin
            cmd.take    = 1'b1;
            cmd.deliver = 1'b1;
         end
         lpmq_pkg::S_WAIT: cmd.load = 1'b0;
         default: busy = 1'b1;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpmq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> bench/length_prefixed_message_queue_checker.sv
// reply predictor and comparator for the length-prefixed message queue
`timescale 1ns / 1ps
module length_prefixed_message_queue_checker #(
   parameter int RING_BYTES = 1024,
   parameter int MAX_READ   = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_func,
   input  logic [9:0]  req_message_length,
   input  logic [7:0]  req_data_byte,
   input  logic [6:0]  req_read_limit,
   input  logic        rsp_strobe,
   input  logic [3:0]  rsp_status,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_last,
   input  logic [9:0]  rsp_popped_length,
   output int unsigned pending_replies,
   output int unsigned mismatch_count
);

   localparam int PTR_W = $clog2(RING_BYTES);

   // one reply as the queue should present it
   typedef struct {
      lpmq_pkg::lpmq_status_type status;
      logic [7:0]                out_byte;
      logic                      last;
      logic [9:0]                popped_length;
   } queue_reply_type;

   queue_reply_type  queued_replies[$];

   // shadow copy of the ring and its bookkeeping
   logic [7:0]       ring_copy [RING_BYTES];
   logic [PTR_W-1:0] rd_ptr;
   logic [PTR_W-1:0] wr_ptr;
   logic [PTR_W:0]   fill_level;
   logic [9:0]       bytes_due;
   logic [9:0]       open_length;
   int unsigned      mismatches = 0;

   function automatic logic [PTR_W-1:0] next_pos(logic [PTR_W-1:0] p);
      return (p == PTR_W'(RING_BYTES - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic void push_byte(logic [7:0] b);
      ring_copy[wr_ptr] = b;
      wr_ptr = next_pos(wr_ptr);
      fill_level = fill_level + 1'b1;
   endfunction

   function automatic logic [7:0] pop_byte();
      logic [7:0] b;
      b = ring_copy[rd_ptr];
      rd_ptr = next_pos(rd_ptr);
      fill_level = fill_level - 1'b1;
      return b;
   endfunction

   function automatic void add_reply(lpmq_pkg::lpmq_status_type st, logic [7:0] b,
                                     logic l, logic [9:0] plen);
      queue_reply_type r;
      r.status = st;
      r.out_byte = b;
      r.last = l;
      r.popped_length = plen;
      queued_replies.push_back(r);
   endfunction

   function automatic void empty_ring();
      rd_ptr = '0;
      wr_ptr = '0;
      fill_level = '0;
      bytes_due = '0;
      open_length = '0;
   endfunction

   // apply one accepted request to the shadow queue and queue its replies
   function automatic void apply_queue_request(lpmq_pkg::lpmq_func_type fn, logic [9:0] len,
                                               logic [7:0] data, logic [6:0] lim);
      int          reader_max;
      int          committed;
      logic [7:0]  hdr0, hdr1, hdr2, hdr3;
      logic [31:0] msg_len;
      reader_max = (int'(lim) > MAX_READ) ? MAX_READ : int'(lim);
      case (fn)
         lpmq_pkg::FN_START: begin
            if (bytes_due != 0) begin
               add_reply(lpmq_pkg::RS_IGNORED, 8'h00, 1'b1, 10'd0);
            end else if (RING_BYTES - int'(fill_level) <
                         int'(len) + int'(lpmq_pkg::HEADER_BYTES)) begin
               add_reply(lpmq_pkg::RS_NO_SPACE, 8'h00, 1'b1, 10'd0);
            end else begin
               // little-endian header, upper two bytes always zero
               push_byte(len[7:0]);
               push_byte({6'b0, len[9:8]});
               push_byte(8'h00);
               push_byte(8'h00);
               bytes_due = len;
               open_length = len;
               add_reply(lpmq_pkg::RS_ACCEPTED, 8'h00, 1'b1, 10'd0);
            end
         end
         lpmq_pkg::FN_DATA: begin
            if (bytes_due == 0) begin
               add_reply(lpmq_pkg::RS_IGNORED, 8'h00, 1'b1, 10'd0);
            end else begin
               push_byte(data);
               bytes_due = bytes_due - 1'b1;
               add_reply(lpmq_pkg::RS_STORED, 8'h00, 1'b1, 10'd0);
            end
         end
         lpmq_pkg::FN_READ: begin
            // the open message, header included, is not readable yet
            committed = int'(fill_level);
            if (bytes_due != 0)
               committed = committed - int'(lpmq_pkg::HEADER_BYTES)
                           - (int'(open_length) - int'(bytes_due));
            if (committed < int'(lpmq_pkg::HEADER_BYTES)) begin
               add_reply(lpmq_pkg::RS_EMPTY, 8'h00, 1'b1, 10'd0);
            end else begin
               hdr0 = pop_byte();
               hdr1 = pop_byte();
               hdr2 = pop_byte();
               hdr3 = pop_byte();
               msg_len = {hdr3, hdr2, hdr1, hdr0};
               committed = committed - int'(lpmq_pkg::HEADER_BYTES);
               if (msg_len > committed)
                  msg_len = committed;
               if (msg_len > reader_max) begin
                  // skip the payload without reading it
                  rd_ptr = PTR_W'((int'(rd_ptr) + msg_len) % RING_BYTES);
                  fill_level = fill_level - msg_len[PTR_W:0];
                  add_reply(lpmq_pkg::RS_DROPPED, 8'h00, 1'b1, msg_len[9:0]);
               end else if (msg_len == 0) begin
                  add_reply(lpmq_pkg::RS_ZERO_LEN, 8'h00, 1'b1, 10'd0);
               end else begin
                  for (int i = 0; i < msg_len; i++)
                     add_reply(lpmq_pkg::RS_BYTE_OUT, pop_byte(), (i + 1 == msg_len),
                               msg_len[9:0]);
               end
            end
         end
         default: begin
            empty_ring();
            add_reply(lpmq_pkg::RS_CLEARED, 8'h00, 1'b1, 10'd0);
         end
      endcase
   endfunction

   // predict on accepted requests, compare every strobed reply with the oldest one due
   always @(posedge clock) begin : watch_channels
      queue_reply_type want;
      if (reset) begin
         empty_ring();
         queued_replies.delete();
      end else begin
         if (start && !busy)
            apply_queue_request(lpmq_pkg::lpmq_func_type'(req_func), req_message_length,
                                req_data_byte, req_read_limit);
         if (rsp_strobe) begin
            if (queued_replies.size() == 0) begin
               $error("reply with none due: rsp_status %0d", rsp_status);
               mismatches++;
            end else begin
               want = queued_replies.pop_front();
               if (rsp_status !== want.status) begin
                  $error("rsp_status mismatch: expected %0d, actual %0d",
                         want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_out_byte !== want.out_byte) begin
                  $error("rsp_out_byte mismatch: expected %0d, actual %0d",
                         want.out_byte, rsp_out_byte);
                  mismatches++;
               end
               if (rsp_last !== want.last) begin
                  $error("rsp_last mismatch: expected %0d, actual %0d", want.last, rsp_last);
                  mismatches++;
               end
               if (rsp_popped_length !== want.popped_length) begin
                  $error("rsp_popped_length mismatch: expected %0d, actual %0d",
                         want.popped_length, rsp_popped_length);
                  mismatches++;
               end
            end
         end
      end
      pending_replies <= queued_replies.size();
      mismatch_count <= mismatches;
   end

endmodule

>>> bench/length_prefixed_message_queue_test.sv
// bench top for the message queue: clock, reset, request traffic and verdict
`timescale 1ns / 1ps
module length_prefixed_message_queue_test;

   localparam int RING_BYTES      = 1024;
   localparam int MAX_READ        = 64;
   localparam int RANDOM_REQUESTS = 380;
   // hang guard limit, far above the worst run of long reads and idle gaps
   localparam int CYCLE_LIMIT     = 500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_func = '0;
   logic [9:0]  req_message_length = '0;
   logic [7:0]  req_data_byte = '0;
   logic [6:0]  req_read_limit = '0;
   logic        rsp_strobe;
   logic [3:0]  rsp_status;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;
   logic [9:0]  rsp_popped_length;
   int unsigned pending_replies;
   int unsigned mismatch_count;
   int unsigned cycle_count = 0;
   bit          idle_on = 1'b1;
   int          random_done = 0;

   always #5 clock = ~clock;

   length_prefixed_message_queue #(
      .RING_BYTES(RING_BYTES),
      .MAX_READ  (MAX_READ)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_message_length(req_message_length),
      .req_data_byte     (req_data_byte),
      .req_read_limit    (req_read_limit),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last          (rsp_last),
      .rsp_popped_length (rsp_popped_length)
   );

   length_prefixed_message_queue_checker #(
      .RING_BYTES(RING_BYTES),
      .MAX_READ  (MAX_READ)
   ) reply_monitor (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_message_length(req_message_length),
      .req_data_byte     (req_data_byte),
      .req_read_limit    (req_read_limit),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last          (rsp_last),
      .rsp_popped_length (rsp_popped_length),
      .pending_replies   (pending_replies),
      .mismatch_count    (mismatch_count)
   );

   // hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // one request: optional idle burst, then hold start until the queue takes it;
   // fields the function does not use carry random values
   task automatic issue_request(input lpmq_pkg::lpmq_func_type fn, input logic [9:0] value);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      start <= 1'b1;
      req_func <= fn;
      req_message_length <= (fn == lpmq_pkg::FN_START) ? value : 10'($urandom);
      req_data_byte <= (fn == lpmq_pkg::FN_DATA) ? value[7:0] : 8'($urandom);
      req_read_limit <= (fn == lpmq_pkg::FN_READ) ? value[6:0] : 7'($urandom);
      do @(posedge clock); while (busy);
   endtask

   // stop requesting until every predicted reply has come back
   task automatic drain_replies();
      start <= 1'b0;
      @(posedge clock);
      while (pending_replies != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int kind;
      int pick;
      int msg_len;
      int stop_at;
      int extra;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty read, orphan byte, zero-length message
      issue_request(lpmq_pkg::FN_READ, 10'd0);
      issue_request(lpmq_pkg::FN_DATA, 10'h000);
      issue_request(lpmq_pkg::FN_START, 10'd0);
      issue_request(lpmq_pkg::FN_READ, 10'd0);
      // start while open, byte extremes, surplus byte, limit above the reader max
      issue_request(lpmq_pkg::FN_START, 10'd3);
      issue_request(lpmq_pkg::FN_START, 10'd7);
      issue_request(lpmq_pkg::FN_DATA, 10'h000);
      issue_request(lpmq_pkg::FN_DATA, 10'h0ff);
      issue_request(lpmq_pkg::FN_DATA, 10'h0a5);
      issue_request(lpmq_pkg::FN_DATA, 10'h05a);
      issue_request(lpmq_pkg::FN_READ, 10'd127);
      // read of an unfinished message, then an over-limit drop
      issue_request(lpmq_pkg::FN_START, 10'd2);
      issue_request(lpmq_pkg::FN_DATA, 10'h012);
      issue_request(lpmq_pkg::FN_READ, 10'd64);
      issue_request(lpmq_pkg::FN_DATA, 10'h034);
      issue_request(lpmq_pkg::FN_READ, 10'd1);
      // over-long start, exact fit, clear
      issue_request(lpmq_pkg::FN_START, 10'd1023);
      issue_request(lpmq_pkg::FN_START, 10'd1020);
      issue_request(lpmq_pkg::FN_READ, 10'd64);
      issue_request(lpmq_pkg::FN_CLEAR, 10'd0);
      // zero limit against empty and one-byte payloads
      issue_request(lpmq_pkg::FN_START, 10'd0);
      issue_request(lpmq_pkg::FN_READ, 10'd0);
      issue_request(lpmq_pkg::FN_START, 10'd1);
      issue_request(lpmq_pkg::FN_DATA, 10'h080);
      issue_request(lpmq_pkg::FN_READ, 10'd0);

      // random traffic, mostly well-formed messages with noise mixed in
      while (random_done < RANDOM_REQUESTS) begin
         if (random_done >= RANDOM_REQUESTS - 60)
            idle_on = 1'b0;
         else if ($urandom_range(0, 5) == 0)
            idle_on = ($urandom_range(0, 2) != 0);
         kind = $urandom_range(0, 99);
         if (kind < 25) begin
            issue_request(lpmq_pkg::FN_START, 10'd0);
            random_done++;
         end else if (kind < 60) begin
            // one message, sometimes abandoned early or followed by a surplus byte
            pick = $urandom_range(0, 19);
            if (pick < 15)
               msg_len = $urandom_range(1, 8);
            else if (pick < 18)
               msg_len = $urandom_range(9, 63);
            else
               msg_len = 64;
            stop_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, msg_len - 1) : msg_len;
            issue_request(lpmq_pkg::FN_START, 10'(msg_len));
            for (int i = 0; i < stop_at; i++) begin
               if ($urandom_range(0, 11) == 0) begin
                  issue_request($urandom_range(0, 1) ? lpmq_pkg::FN_START : lpmq_pkg::FN_READ,
                                10'($urandom));
                  random_done++;
               end
               issue_request(lpmq_pkg::FN_DATA, 10'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 9) == 0) begin
               issue_request(lpmq_pkg::FN_DATA, 10'($urandom_range(0, 255)));
               random_done++;
            end
            random_done += stop_at + 1;
         end else if (kind < 84) begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
               issue_request(lpmq_pkg::FN_READ, 10'($urandom_range(64, 127)));
            else if (pick < 8)
               issue_request(lpmq_pkg::FN_READ, 10'($urandom_range(0, 64)));
            else
               issue_request(lpmq_pkg::FN_READ, 10'($urandom_range(0, 4)));
            random_done++;
         end else if (kind < 90) begin
            issue_request(lpmq_pkg::FN_DATA, 10'($urandom_range(0, 255)));
            random_done++;
         end else if (kind < 97) begin
            // large start against the current fill; if it fits, abandon it with a clear
            drain_replies();
            issue_request(lpmq_pkg::FN_START, 10'($urandom_range(700, 1023)));
            start <= 1'b0;
            do @(posedge clock); while (!rsp_strobe);
            random_done++;
            if (rsp_status == lpmq_pkg::RS_ACCEPTED) begin
               extra = $urandom_range(1, 6);
               repeat (extra) issue_request(lpmq_pkg::FN_DATA, 10'($urandom_range(0, 255)));
               issue_request(lpmq_pkg::FN_CLEAR, 10'($urandom));
               random_done += extra + 1;
            end
         end else begin
            issue_request(lpmq_pkg::FN_CLEAR, 10'($urandom));
            random_done++;
         end
      end

      drain_replies();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
